// File: sv/collision_event_queue_defines.svh
// Assertion macros for the collision event queue.
// Included by the top level; depends on nothing else.
`ifndef COLLISION_EVENT_QUEUE_DEFINES_SVH
`define COLLISION_EVENT_QUEUE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define CEVQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cevq check failed");

// Check that a condition implies a consequence in the next cycle.
`define CEVQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cevq check failed");

`endif

// File: sv/cevq_pkg.sv
// Shared types and constants for the collision event queue.
// Used by the queue cell and the top level; depends on nothing.
`default_nettype none

package cevq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int PARTICLE_BITS = 10;
    localparam int TIME_BITS     = 64;
    localparam int IDX_BITS      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int PCOUNT_BITS   = 11;
    localparam int TALLY_BITS    = 32;

    localparam logic [PCOUNT_BITS-1:0] PCOUNT_RESET = PCOUNT_BITS'(1024);

    // Input tdata layout, lowest bit first
    localparam int S_TIME_LO   = 0;
    localparam int S_FIRST_LO  = S_TIME_LO + TIME_BITS;
    localparam int S_SECOND_LO = S_FIRST_LO + PARTICLE_BITS;
    localparam int S_PURGE_LO  = S_SECOND_LO + PARTICLE_BITS;
    localparam int S_FIELD_BITS = S_PURGE_LO + PARTICLE_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;

    // Result tdata layout, lowest bit first
    localparam int M_FIELD_BITS = TIME_BITS + 2 * PARTICLE_BITS + COUNT_BITS + TALLY_BITS + 3;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [TIME_BITS-1:0]     event_time;
        logic [PARTICLE_BITS-1:0] first;
        logic [PARTICLE_BITS-1:0] second;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_PURGE_MARK,
        OP_COMPACT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        entry_t                   entry;
        logic [PARTICLE_BITS-1:0] purge;
    } cell_cmd_t;

    // What a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   after;
        entry_t entry;
    } cell_link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_RESP
    } ctrl_state_t;

endpackage

`default_nettype wire

// File: sv/cevq_cell.sv
// One slot of the sorted event chain: holds an entry and its valid bit.
// Depends on cevq_pkg for the entry, command and link types.
`default_nettype none

module cevq_cell (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  cevq_pkg::cell_cmd_t  cmd,
    input  cevq_pkg::cell_link_t prev_link,
    input  cevq_pkg::cell_link_t next_link,
    output cevq_pkg::cell_link_t link,
    output logic                 dup
);

    cevq_pkg::entry_t entry_reg, entry_next;
    logic             valid_reg, valid_next;
    logic             after;

    // Compare the stored time with the incoming one
    assign after = valid_reg && (entry_reg.event_time <= cmd.entry.event_time);
    assign dup   = valid_reg && (entry_reg.event_time == cmd.entry.event_time);

    assign link.valid = valid_reg;
    assign link.after = after;
    assign link.entry = entry_reg;

    // Choose the new content of the slot
    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        unique case (cmd.op)
            cevq_pkg::OP_INSERT: begin
                if (!after) begin
                    if (prev_link.after) begin
                        entry_next = cmd.entry;
                        valid_next = 1'b1;
                    end else begin
                        entry_next = prev_link.entry;
                        valid_next = prev_link.valid;
                    end
                end
            end
            cevq_pkg::OP_PURGE_MARK: begin
                if (valid_reg && (entry_reg.first == cmd.purge ||
                                  entry_reg.second == cmd.purge)) begin
                    valid_next = 1'b0;
                end
            end
            cevq_pkg::OP_COMPACT: begin
                // pull the upper neighbor into a hole; hand ours down into one
                if (!valid_reg) begin
                    entry_next = next_link.entry;
                    valid_next = next_link.valid;
                end else if (!prev_link.valid) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/collision_event_queue.sv
// Insert: update the chain, then load the result register once it is free or taken.
// Purge: mark matching entries, then compact until no hole is left; holes move up
// one slot per pass through the cell chain. Purge on an empty table: no compaction.
// One request is in work at a time; a finished result may wait while the next is taken.
// Synchronous active-low reset empties the table and clears the tally; particle_count
// returns to 1024.
`default_nettype none

module collision_event_queue (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    // configuration: particle_count
    input  wire                                    cfg_wr_en,
    input  wire  [cevq_pkg::PCOUNT_BITS-1:0]       cfg_wr_data,
    // request channel
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    // tdata: event_time, first_particle, second_particle, purge_particle, zero pad
    input  wire  [cevq_pkg::S_TDATA_BITS-1:0]      s_tdata,
    // tuser: mode
    input  wire  [0:0]                             s_tuser,
    // result channel
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    // tdata: head_time, head_first, head_second, entry_count, duplicates_seen,
    //        insert_dropped, index_error, purge_on_empty, zero pad
    output logic [cevq_pkg::M_TDATA_BITS-1:0]      m_tdata,
    // tuser: head_valid
    output logic [0:0]                             m_tuser
);

    localparam int D = cevq_pkg::QUEUE_DEPTH;

    cevq_pkg::ctrl_state_t state_reg, state_next;
    cevq_pkg::cell_cmd_t   cmd;
    cevq_pkg::cell_link_t  links [D];
    cevq_pkg::cell_link_t  prev_links [D];
    cevq_pkg::cell_link_t  next_links [D];
    logic [D-1:0]          dup_bits;
    logic [D-1:0]          top_bits;
    logic [D-2:0]          gap_bits;

    logic [cevq_pkg::PCOUNT_BITS-1:0] pcount_reg;
    logic [cevq_pkg::COUNT_BITS-1:0]  count_reg, count_next;
    logic [cevq_pkg::TALLY_BITS-1:0]  tally_reg, tally_next;
    logic                             drop_reg, idx_err_reg, purge_empty_reg;

    logic                             m_valid_reg, m_valid_next;
    logic                             head_valid_reg;
    cevq_pkg::entry_t                 head_reg;
    logic [cevq_pkg::COUNT_BITS-1:0]  out_count_reg;
    logic [cevq_pkg::TALLY_BITS-1:0]  out_tally_reg;
    logic                             out_drop_reg, out_idx_reg, out_pe_reg;

    logic                             accept, is_purge, full, empty;
    logic                             dup_any, busy, idx_err, resp_load;
    cevq_pkg::entry_t                 in_entry;
    logic [cevq_pkg::PARTICLE_BITS-1:0] in_purge;
    logic [cevq_pkg::IDX_BITS-1:0]    top_idx;
    logic [cevq_pkg::COUNT_BITS-1:0]  packed_count;

    // Unpack the request
    assign in_entry.event_time = s_tdata[cevq_pkg::S_TIME_LO +: cevq_pkg::TIME_BITS];
    assign in_entry.first      = s_tdata[cevq_pkg::S_FIRST_LO +: cevq_pkg::PARTICLE_BITS];
    assign in_entry.second     = s_tdata[cevq_pkg::S_SECOND_LO +: cevq_pkg::PARTICLE_BITS];
    assign in_purge            = s_tdata[cevq_pkg::S_PURGE_LO +: cevq_pkg::PARTICLE_BITS];
    assign is_purge            = s_tuser[0];

    assign s_tready  = (state_reg == cevq_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    // Load the result once the result register is free or being taken
    assign resp_load = (state_reg == cevq_pkg::ST_RESP) && (!m_valid_reg || m_tready);
    assign full      = links[D-1].valid;
    assign empty     = (count_reg == '0);
    assign idx_err   = (cevq_pkg::PCOUNT_BITS'(in_entry.first) >= pcount_reg) ||
                       (cevq_pkg::PCOUNT_BITS'(in_entry.second) >= pcount_reg);

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < D; gi++) begin : g_cell
            if (gi == 0) begin : g_bottom
                assign prev_links[gi].valid = 1'b1;
                assign prev_links[gi].after = 1'b1;
                assign prev_links[gi].entry = '0;
            end else begin : g_mid_lo
                assign prev_links[gi] = links[gi-1];
            end
            if (gi == D-1) begin : g_top
                assign next_links[gi] = '0;
                assign top_bits[gi]   = links[gi].valid;
            end else begin : g_mid_hi
                assign next_links[gi] = links[gi+1];
                assign top_bits[gi]   = links[gi].valid && !links[gi+1].valid;
                assign gap_bits[gi]   = !links[gi].valid && links[gi+1].valid;
            end
            cevq_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .prev_link (prev_links[gi]),
                .next_link (next_links[gi]),
                .link      (links[gi]),
                .dup       (dup_bits[gi])
            );
        end
    endgenerate

    assign dup_any = |dup_bits;
    assign busy    = |gap_bits;

    // Encode the topmost valid slot to get the count after compaction
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < D; i++) begin
            top_idx = top_idx | (top_bits[i] ? cevq_pkg::IDX_BITS'(i) : '0);
        end
        packed_count = links[0].valid ?
            (cevq_pkg::COUNT_BITS'(top_idx) + cevq_pkg::COUNT_BITS'(1)) : '0;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cevq_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (is_purge && !empty) ? cevq_pkg::ST_COMPACT
                                                      : cevq_pkg::ST_RESP;
                end
            end
            cevq_pkg::ST_COMPACT: begin
                if (!busy) begin
                    state_next = cevq_pkg::ST_RESP;
                end
            end
            cevq_pkg::ST_RESP: begin
                if (resp_load) begin
                    state_next = cevq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cevq_pkg::ST_IDLE;
            end
        endcase
    end

    // Cell command
    always_comb begin
        cmd.op    = cevq_pkg::OP_HOLD;
        cmd.entry = in_entry;
        cmd.purge = in_purge;
        unique case (state_reg)
            cevq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!is_purge && !full) begin
                        cmd.op = cevq_pkg::OP_INSERT;
                    end else if (is_purge && !empty) begin
                        cmd.op = cevq_pkg::OP_PURGE_MARK;
                    end
                end
            end
            cevq_pkg::ST_COMPACT: begin
                cmd.op = cevq_pkg::OP_COMPACT;
            end
            default: begin
                cmd.op = cevq_pkg::OP_HOLD;
            end
        endcase
    end

    // Count and tally updates
    always_comb begin
        count_next = count_reg;
        tally_next = tally_reg;
        if (accept && !is_purge && !full) begin
            count_next = count_reg + cevq_pkg::COUNT_BITS'(1);
            if (dup_any && (tally_reg != '1)) begin
                tally_next = tally_reg + cevq_pkg::TALLY_BITS'(1);
            end
        end else if ((state_reg == cevq_pkg::ST_COMPACT) && !busy) begin
            count_next = packed_count;
        end
    end

    // Result valid: set when a result is loaded, clear when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (resp_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cevq_pkg::ST_IDLE;
            pcount_reg  <= cevq_pkg::PCOUNT_RESET;
            count_reg   <= '0;
            tally_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tally_reg   <= tally_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                pcount_reg <= cfg_wr_data;
            end
        end
    end

    // Hold the flags of the request in work
    always_ff @(posedge aclk) begin
        if (accept) begin
            drop_reg        <= !is_purge && full;
            idx_err_reg     <= !is_purge && idx_err;
            purge_empty_reg <= is_purge && empty;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (resp_load) begin
            head_valid_reg <= links[0].valid;
            head_reg       <= links[0].valid ? links[0].entry : '0;
            out_count_reg  <= count_reg;
            out_tally_reg  <= tally_reg;
            out_drop_reg   <= drop_reg;
            out_idx_reg    <= idx_err_reg;
            out_pe_reg     <= purge_empty_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = head_valid_reg;
    assign m_tdata  = cevq_pkg::M_TDATA_BITS'({out_pe_reg, out_idx_reg, out_drop_reg,
                                               out_tally_reg, out_count_reg,
                                               head_reg.second, head_reg.first,
                                               head_reg.event_time});

    `include "collision_event_queue_defines.svh"

    `CEVQ_ASSERT_SAME(a_count_range, aclk, aresetn, 1'b1, count_reg <= cevq_pkg::COUNT_BITS'(D))
    `CEVQ_ASSERT_NEXT(a_insert_grows, aclk, aresetn, accept && !is_purge && !full, count_reg == $past(count_reg) + cevq_pkg::COUNT_BITS'(1))
    `CEVQ_ASSERT_NEXT(a_resp_loads, aclk, aresetn, state_reg == cevq_pkg::ST_RESP, m_tvalid)
    `CEVQ_ASSERT_SAME(a_head_matches_count, aclk, aresetn, state_reg == cevq_pkg::ST_IDLE, links[0].valid == (count_reg != '0))

endmodule

`default_nettype wire

// File: verif/collision_event_queue_test.sv
// Testbench for collision_event_queue: sends insert and purge requests over the stream
// ports, keeps its own sorted copy of the event table and checks every result against it.
// Depends on cevq_pkg and the collision_event_queue RTL.
module collision_event_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH   = cevq_pkg::QUEUE_DEPTH;
    localparam int TIME_BITS     = cevq_pkg::TIME_BITS;
    localparam int PARTICLE_BITS = cevq_pkg::PARTICLE_BITS;
    localparam int COUNT_BITS    = cevq_pkg::COUNT_BITS;
    localparam int TALLY_BITS    = cevq_pkg::TALLY_BITS;
    localparam int PCOUNT_BITS   = cevq_pkg::PCOUNT_BITS;
    localparam int S_TDATA_BITS  = cevq_pkg::S_TDATA_BITS;
    localparam int M_TDATA_BITS  = cevq_pkg::M_TDATA_BITS;
    localparam int S_TIME_LO     = cevq_pkg::S_TIME_LO;
    localparam int S_FIRST_LO    = cevq_pkg::S_FIRST_LO;
    localparam int S_SECOND_LO   = cevq_pkg::S_SECOND_LO;
    localparam int S_PURGE_LO    = cevq_pkg::S_PURGE_LO;
    localparam logic [PCOUNT_BITS-1:0] PCOUNT_RESET = cevq_pkg::PCOUNT_RESET;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_PURGE  = 1'b1;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;
    localparam int STALL_CYCLES = 300;

    // Result tdata layout, lowest bit first
    localparam int M_FIRST_LO   = TIME_BITS;
    localparam int M_SECOND_LO  = M_FIRST_LO + PARTICLE_BITS;
    localparam int M_COUNT_LO   = M_SECOND_LO + PARTICLE_BITS;
    localparam int M_TALLY_LO   = M_COUNT_LO + COUNT_BITS;
    localparam int M_DROP_BIT   = M_TALLY_LO + TALLY_BITS;
    localparam int M_IDXERR_BIT = M_DROP_BIT + 1;
    localparam int M_PEMPTY_BIT = M_IDXERR_BIT + 1;

    typedef logic [TIME_BITS-1:0]     evt_time_t;
    typedef logic [PARTICLE_BITS-1:0] particle_t;

    typedef struct packed {
        logic                  head_valid;
        evt_time_t             head_time;
        particle_t             head_a;
        particle_t             head_b;
        logic [COUNT_BITS-1:0] entry_count;
        logic [TALLY_BITS-1:0] duplicates;
        logic                  insert_dropped;
        logic                  index_error;
        logic                  purge_on_empty;
    } head_report_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [PCOUNT_BITS-1:0]  cfg_wr_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic [0:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [0:0]              m_tuser;

    // Shadow of the event table, sorted by time
    evt_time_t             table_time [QUEUE_DEPTH];
    particle_t             table_a [QUEUE_DEPTH];
    particle_t             table_b [QUEUE_DEPTH];
    int                    held_events = 0;
    logic [TALLY_BITS-1:0] dup_tally = '0;
    logic [PCOUNT_BITS-1:0] particle_limit = PCOUNT_RESET;

    head_report_t pending_reports[$];
    int           mismatch_count = 0;
    int           result_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           stall_left = 0;
    particle_t    particle_pool [16];
    evt_time_t    recent_times [8];

    always #5 aclk = ~aclk;

    collision_event_queue DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Apply one request to the shadow table and return the head report it yields
    function automatic head_report_t apply_to_schedule(logic mode, evt_time_t t,
                                                       particle_t a, particle_t b,
                                                       particle_t p);
        head_report_t rep;
        int           pos;
        int           kept;
        logic         dup;
        rep  = '0;
        pos  = 0;
        kept = 0;
        dup  = 1'b0;
        if (mode == MODE_INSERT) begin
            rep.index_error = (a >= particle_limit) || (b >= particle_limit);
            if (held_events >= QUEUE_DEPTH) begin
                rep.insert_dropped = 1'b1;
            end else begin
                // place after every event with an earlier or equal time
                for (int k = 0; k < held_events; k++) begin
                    if (table_time[k] == t) dup = 1'b1;
                    if (table_time[k] <= t) pos = k + 1;
                end
                for (int k = held_events; k > pos; k--) begin
                    table_time[k] = table_time[k-1];
                    table_a[k]    = table_a[k-1];
                    table_b[k]    = table_b[k-1];
                end
                table_time[pos] = t;
                table_a[pos]    = a;
                table_b[pos]    = b;
                held_events++;
                if (dup && dup_tally != '1) dup_tally++;
            end
        end else if (held_events == 0) begin
            rep.purge_on_empty = 1'b1;
        end else begin
            // drop every event naming the particle, close up the rest in order
            for (int k = 0; k < held_events; k++) begin
                if (table_a[k] != p && table_b[k] != p) begin
                    table_time[kept] = table_time[k];
                    table_a[kept]    = table_a[k];
                    table_b[kept]    = table_b[k];
                    kept++;
                end
            end
            held_events = kept;
        end
        if (held_events > 0) begin
            rep.head_valid = 1'b1;
            rep.head_time  = table_time[0];
            rep.head_a     = table_a[0];
            rep.head_b     = table_b[0];
        end
        rep.entry_count = COUNT_BITS'(held_events);
        rep.duplicates  = dup_tally;
        return rep;
    endfunction

    // Times biased toward repeats and small integer parts
    function automatic evt_time_t random_time();
        int        pick;
        evt_time_t t;
        pick = $urandom_range(99);
        if (pick < 20) t = recent_times[$urandom_range(7)];
        else if (pick < 30) t = {32'($urandom_range(5)), 32'($urandom_range(3))};
        else if (pick < 33) t = '1;
        else if (pick < 36) t = '0;
        else t = {$urandom, $urandom};
        recent_times[$urandom_range(7)] = t;
        return t;
    endfunction

    function automatic particle_t random_particle();
        if ($urandom_range(99) < 75) return particle_pool[$urandom_range(15)];
        return particle_t'($urandom_range(1023));
    endfunction

    // Offer one request at a falling edge and hold it until accepted
    task automatic send_request(input logic mode, input evt_time_t t, input particle_t a,
                                input particle_t b, input particle_t p);
        logic [S_TDATA_BITS-1:0] word;
        word = '0;
        word[S_TIME_LO +: TIME_BITS]       = t;
        word[S_FIRST_LO +: PARTICLE_BITS]  = a;
        word[S_SECOND_LO +: PARTICLE_BITS] = b;
        word[S_PURGE_LO +: PARTICLE_BITS]  = p;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = word;
        s_tuser  = mode;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_reports.push_back(apply_to_schedule(mode, t, a, b, p));
    endtask

    // Drop valid and wait until every result is back and the block has settled
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_particle_count(input logic [PCOUNT_BITS-1:0] value);
        wait_idle();
        cfg_wr_data = value;
        cfg_wr_en   = 1'b1;
        @(negedge aclk);
        cfg_wr_en      = 1'b0;
        particle_limit = value;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         result_count, name, want, got);
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        head_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d: arrived with no request outstanding", result_count);
            end else begin
                want = pending_reports.pop_front();
                check_field("head_valid", 64'(want.head_valid), 64'(m_tuser[0]));
                check_field("head_time", 64'(want.head_time),
                            64'(m_tdata[0 +: TIME_BITS]));
                check_field("head_first", 64'(want.head_a),
                            64'(m_tdata[M_FIRST_LO +: PARTICLE_BITS]));
                check_field("head_second", 64'(want.head_b),
                            64'(m_tdata[M_SECOND_LO +: PARTICLE_BITS]));
                check_field("entry_count", 64'(want.entry_count),
                            64'(m_tdata[M_COUNT_LO +: COUNT_BITS]));
                check_field("duplicates_seen", 64'(want.duplicates),
                            64'(m_tdata[M_TALLY_LO +: TALLY_BITS]));
                check_field("insert_dropped", 64'(want.insert_dropped),
                            64'(m_tdata[M_DROP_BIT]));
                check_field("index_error", 64'(want.index_error),
                            64'(m_tdata[M_IDXERR_BIT]));
                check_field("purge_on_empty", 64'(want.purge_on_empty),
                            64'(m_tdata[M_PEMPTY_BIT]));
            end
        end
    end

    // Receiver: random ready, or a forced hold-off while stall_left runs down
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Empty purge, duplicate times, extreme times and indices, purge down to empty
    task automatic test_directed();
        evt_time_t three;
        three = evt_time_t'(3) << 32;
        send_request(MODE_PURGE, '1, '1, '1, 10'd3);
        send_request(MODE_INSERT, three, 10'd1, 10'd2, '1);
        send_request(MODE_INSERT, three, 10'd3, 10'd4, '0);
        send_request(MODE_INSERT, three, 10'd5, 10'd6, 10'd3);
        send_request(MODE_INSERT, '1, 10'd1023, 10'd1023, '0);
        send_request(MODE_INSERT, '0, 10'd0, 10'd1023, '0);
        send_request(MODE_INSERT, (evt_time_t'(2) << 32) + 1, 10'd2, 10'd9, '0);
        send_request(MODE_INSERT, (evt_time_t'(2) << 32) + 1, 10'd7, 10'd8, '0);
        send_request(MODE_PURGE, '0, '0, '0, 10'd1023);
        send_request(MODE_PURGE, '1, '1, '1, 10'd500);
        send_request(MODE_PURGE, '0, '0, '0, 10'd1);
        send_request(MODE_PURGE, '0, '0, '0, 10'd3);
        send_request(MODE_PURGE, '0, '0, '0, 10'd5);
        send_request(MODE_PURGE, '0, '0, '0, 10'd8);
        send_request(MODE_PURGE, '0, '0, '0, 10'd2);
        send_request(MODE_PURGE, '1, '1, '1, 10'd0);
    endtask

    // Hold the result side off so the table fills, drops inserts and stalls input
    task automatic test_backpressure();
        @(posedge aclk);
        stall_left = STALL_CYCLES;
        repeat (QUEUE_DEPTH + 6)
            send_request(MODE_INSERT, {$urandom, $urandom}, 10'd5,
                         particle_t'($urandom), particle_t'($urandom));
        send_request(MODE_PURGE, {$urandom, $urandom}, particle_t'($urandom),
                     particle_t'($urandom), 10'd5);
    endtask

    // Index checks against zero, one, the largest count and a random count
    task automatic test_particle_count();
        logic [PCOUNT_BITS-1:0] limits [4];
        particle_t              bound;
        limits = '{11'd0, 11'd1, 11'd2047, PCOUNT_BITS'($urandom_range(2, 1023))};
        foreach (limits[i]) begin
            write_particle_count(limits[i]);
            for (int j = 0; j < 3; j++) begin
                if (j == 0) bound = particle_t'(limits[i] - 1);
                else if (j == 1) bound = particle_t'(limits[i]);
                else bound = particle_t'($urandom);
                send_request(MODE_INSERT, random_time(), bound, 10'd0, particle_t'($urandom));
                send_request(MODE_INSERT, random_time(), 10'd0, bound, particle_t'($urandom));
            end
            send_request(MODE_PURGE, random_time(), particle_t'($urandom),
                         particle_t'($urandom), 10'd0);
        end
        write_particle_count(PCOUNT_RESET);
    endtask

    // Mixed inserts and purges over a small particle pool, with occasional fill bursts
    task automatic test_random_traffic(input int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0 && $urandom_range(99) < 3) burst = 24;
            if (burst > 0 || $urandom_range(99) < 55) begin
                send_request(MODE_INSERT, random_time(), random_particle(),
                             random_particle(), particle_t'($urandom));
                if (burst > 0) burst--;
            end else begin
                send_request(MODE_PURGE, random_time(), particle_t'($urandom),
                             particle_t'($urandom), random_particle());
            end
        end
    endtask

    initial begin
        particle_pool[0] = '0;
        particle_pool[1] = '1;
        for (int i = 2; i < 16; i++) particle_pool[i] = particle_t'($urandom_range(1023));
        foreach (recent_times[i]) recent_times[i] = {$urandom, $urandom};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 75;
        test_directed();
        test_backpressure();
        test_random_traffic(130);

        send_idle_pct = 75;
        recv_idle_pct = 32;
        test_particle_count();
        test_random_traffic(110);

        write_particle_count(PCOUNT_BITS'($urandom_range(1, 1024)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100);

        wait_idle();
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("PASS collision_event_queue");
        else
            $display("FAIL collision_event_queue");
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL collision_event_queue");
        $finish;
    end

endmodule
